>>> design/cwm_pkg.sv
// cwm_pkg: shared constants, register indexes and control types for the
// cross-window morphology block. No dependencies.
package cwm_pkg;

    localparam int PIX_W     = 8;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int ROW_W     = 13;
    localparam int CNT_W     = FW_W + FH_W;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_VALUE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_MODE   = 2'd3;

    localparam logic [FW_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0]  HEIGHT_RST = 12'd1024;
    localparam logic [FH_W-1:0]  MIN_SIZE   = 12'd3;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

    // per-item control decided when the beat is accepted
    typedef struct packed {
        logic emit;
        logic done;
        logic interior;
        logic zero_pix;
    } cwm_ctrl_t;

endpackage

>>> design/cwm_stream_if.sv
// cwm_stream_if: valid/ready channels for input and result pixels.
// Depends on cwm_pkg for field widths.
interface cwm_pix_in_if import cwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             is_filler;

    modport source (output valid, output pixel_in, output is_filler, input ready);
    modport sink   (input valid, input pixel_in, input is_filler, output ready);
endinterface

interface cwm_pix_out_if import cwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

>>> design/cwm_cell.sv
// cwm_cell: one window register of the cross window; shifts toward its
// neighbor on every advancing beat and flags a match with the compare value.
// Depends on cwm_pkg.
module cwm_cell
    import cwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [PIX_W-1:0] d,
    input  logic [PIX_W-1:0] tv,
    output logic [PIX_W-1:0] q,
    output logic             hit
);

    logic [PIX_W-1:0] q_reg;
    logic [PIX_W-1:0] q_next;

    assign q_next = en ? d : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q   = q_reg;
    assign hit = (q_reg == tv);

endmodule

>>> design/cwm_linebuf.sv
// cwm_linebuf: the two previous rows, one memory each, read at acceptance
// and written when the item leaves the window stage. Depends on cwm_pkg.
module cwm_linebuf
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [CW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [CW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_pix,
    output logic [PIX_W-1:0] top_pix,
    output logic [PIX_W-1:0] mid_pix
);

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] mid_reg;

    // middle row moves up; the new pixel becomes the middle row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= mid_reg;
            middle_mem[wr_addr] <= wr_pix;
        end
        if (rd_en)
        begin
            top_reg <= upper_mem[rd_addr];
            mid_reg <= middle_mem[rd_addr];
        end
    end

    assign top_pix = top_reg;
    assign mid_pix = mid_reg;

endmodule

>>> design/cwm_seq.sv
// cwm_seq: configuration registers and raster position counters; decides
// per accepted beat the column, whether it emits, ends the frame, or is
// interior. Depends on cwm_pkg.
module cwm_seq
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 accept,
    input  logic                 is_filler,
    output logic [CW-1:0]        col,
    output cwm_ctrl_t            ctrl,
    output logic [PIX_W-1:0]     tv
);

    function automatic logic [FW_W-1:0] clamp_width(input logic [FW_W-1:0] v);
        logic [FW_W-1:0] w;
        w = v;
        if (w < FW_W'(MIN_SIZE))
        begin
            w = FW_W'(MIN_SIZE);
        end
        if (32'(w) > 32'(MAX_WIDTH))
        begin
            w = FW_W'(MAX_WIDTH);
        end
        return w;
    endfunction

    localparam logic [FW_W-1:0]  W_RST    = (MAX_WIDTH < 1024) ? FW_W'(MAX_WIDTH) : WIDTH_RST;
    localparam logic [CNT_W-1:0] PROD_RST = CNT_W'(32'(W_RST) * 32'(HEIGHT_RST) - 1);

    logic [FW_W-1:0]  width_reg,  width_next;
    logic [FH_W-1:0]  height_reg, height_next;
    logic [PIX_W-1:0] target_reg, target_next;
    logic             mode_reg,   mode_next;
    logic [CNT_W-1:0] prod_reg,   prod_next;
    logic [CW-1:0]    col_reg,    col_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    logic [FW_W-1:0]  w_new;
    logic [FH_W-1:0]  h_new;
    logic [FW_W-1:0]  mul_w;
    logic [FH_W-1:0]  mul_h;
    logic [CW-1:0]    c;
    logic             last_col;
    logic             emit;
    logic             done;

    // configuration; frame size product kept as count of the last pixel
    always_comb
    begin
        w_new       = clamp_width(cfg_wdata[FW_W-1:0]);
        h_new       = (cfg_wdata[FH_W-1:0] < MIN_SIZE) ? MIN_SIZE : cfg_wdata[FH_W-1:0];
        width_next  = width_reg;
        height_next = height_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        mul_w       = width_reg;
        mul_h       = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_next = w_new;
                    mul_w      = w_new;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = h_new;
                    mul_h       = h_new;
                end
                REG_TARGET_VALUE: target_next = cfg_wdata[PIX_W-1:0];
                REG_MORPH_MODE:   mode_next   = cfg_wdata[0];
                default:          ;
            endcase
        end
        prod_next = CNT_W'(mul_w) * CNT_W'(mul_h) - CNT_W'(1);
    end

    assign tv = mode_reg ? (PIX_MAX - target_reg) : target_reg;

    // position of the beat now at the input
    always_comb
    begin
        if (32'(col_reg) >= 32'(width_reg))
        begin
            c = CW'(width_reg - FW_W'(1));
        end
        else
        begin
            c = col_reg;
        end
        last_col = (32'(c) == 32'(width_reg) - 32'd1);
        emit     = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && c != '0);
        done     = emit && (cnt_reg >= prod_reg);

        ctrl.emit     = emit;
        ctrl.done     = done;
        ctrl.interior = (row_reg >= ROW_W'(2)) && (32'(row_reg) < 32'(height_reg))
                        && (32'(c) >= 32'd2);
        ctrl.zero_pix = is_filler || (32'(row_reg) >= 32'(height_reg));

        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (done)
            begin
                col_next = '0;
                row_next = '0;
                cnt_next = '0;
            end
            else
            begin
                if (last_col)
                begin
                    col_next = '0;
                    // saturate: compares against the height stay the same
                    row_next = (row_reg == '1) ? row_reg : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = c + CW'(1);
                end
                if (emit)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign col = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= W_RST;
            height_reg <= HEIGHT_RST;
            target_reg <= '0;
            mode_reg   <= 1'b0;
            prod_reg   <= PROD_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            target_reg <= target_next;
            mode_reg   <= mode_next;
            prod_reg   <= prod_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> design/cross_window_morphology.sv
// cross_window_morphology: 3x3 cross erosion/dilation on a raster stream.
// Throughput: one beat per cycle while the output is not stalled, set by one read and one
// write per cycle on each line store. A result is registered when the beat that completes
// its cross leaves the window stage, i.e. one row and one pixel after its own pixel.
// Reset: counters and window cleared, registers at defaults; line stores not cleared.
module cross_window_morphology
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cwm_pix_in_if.sink           pix_in,
    cwm_pix_out_if.source        pix_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic             in_acc;
    logic             adv;
    logic             out_free;
    logic [CW-1:0]    seq_col;
    cwm_ctrl_t        seq_ctrl;
    logic [PIX_W-1:0] tv;

    logic             valid1_reg, valid1_next;
    cwm_ctrl_t        ctrl1_reg;
    logic [CW-1:0]    col1_reg;
    logic [PIX_W-1:0] pix1_reg;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_end_reg;

    logic [PIX_W-1:0] top_pix;
    logic [PIX_W-1:0] mid_pix;
    logic [PIX_W-1:0] up1_q, mid0_q, mid1_q, low1_q;
    logic             up1_hit, mid0_hit, mid1_hit, low1_hit;
    logic             hit_any;
    logic [PIX_W-1:0] res;

    assign out_free     = !out_valid_reg || pix_out.ready;
    assign adv          = valid1_reg && out_free;
    assign pix_in.ready = !valid1_reg || out_free;
    assign in_acc       = pix_in.valid && pix_in.ready;

    cwm_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (in_acc),
        .is_filler (pix_in.is_filler),
        .col       (seq_col),
        .ctrl      (seq_ctrl),
        .tv        (tv)
    );

    cwm_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (seq_col),
        .wr_en   (adv),
        .wr_addr (col1_reg),
        .wr_pix  (pix1_reg),
        .top_pix (top_pix),
        .mid_pix (mid_pix)
    );

    // window cells: upper center, middle left, middle center, lower center
    cwm_cell u_cell_up1  (.clk(clk), .rst_n(rst_n), .en(adv), .d(top_pix), .tv(tv),
                          .q(up1_q), .hit(up1_hit));
    cwm_cell u_cell_mid0 (.clk(clk), .rst_n(rst_n), .en(adv), .d(mid1_q), .tv(tv),
                          .q(mid0_q), .hit(mid0_hit));
    cwm_cell u_cell_mid1 (.clk(clk), .rst_n(rst_n), .en(adv), .d(mid_pix), .tv(tv),
                          .q(mid1_q), .hit(mid1_hit));
    cwm_cell u_cell_low1 (.clk(clk), .rst_n(rst_n), .en(adv), .d(pix1_reg), .tv(tv),
                          .q(low1_q), .hit(low1_hit));

    // center is the middle cell; its right neighbor is the fresh middle read
    assign hit_any = up1_hit || mid0_hit || mid1_hit || low1_hit || (mid_pix == tv);
    assign res     = (ctrl1_reg.interior && hit_any) ? tv : mid1_q;

    always_comb
    begin
        valid1_next = valid1_reg;
        if (in_acc)
        begin
            valid1_next = 1'b1;
        end
        else if (adv)
        begin
            valid1_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv && ctrl1_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid1_reg    <= valid1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ctrl1_reg <= seq_ctrl;
            col1_reg  <= seq_col;
            pix1_reg  <= seq_ctrl.zero_pix ? '0 : pix_in.pixel_in;
        end
        if (adv && ctrl1_reg.emit)
        begin
            out_pix_reg <= res;
            out_end_reg <= ctrl1_reg.done;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.pixel_out = out_pix_reg;
    assign pix_out.frame_end = out_end_reg;

    // frame end returns the raster position to the first column
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && seq_ctrl.done) |=> (seq_col == '0))
        else $error("column not cleared after frame end");

    a_interior_emits: assert property (@(posedge clk) disable iff (!rst_n)
        seq_ctrl.interior |-> seq_ctrl.emit)
        else $error("interior position without a result");

    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(adv && ctrl1_reg.emit))
        else $error("result raised without an emitting window beat");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && !out_free) |=> valid1_reg)
        else $error("stalled window beat lost");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for cross_window_morphology; drives raster frames over
// the pixel channel, predicts each filtered pixel and frame end, and checks every beat.
// Depends on cwm_pkg, cwm_stream_if and the cross_window_morphology top level.
module tb_top;
    import cwm_pkg::*;

    localparam int          MAX_W        = 1024;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned NO_LIMIT     = 32'hFFFF_FFFF;
    localparam longint      LIMIT_CYCLES = 1_500_000;
    localparam int          RANDOM_ITEMS = 720;
    localparam int          MAX_PRINTS   = 50;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             filler;
    } pix_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } filtered_pix_t;

    // raster position: next column/row/count, plus where the last beat landed
    typedef struct packed {
        int unsigned col;
        int unsigned row;
        int unsigned cnt;
        int unsigned at_col;
        int unsigned at_row;
        logic        emit;
        logic        done;
    } raster_pos_t;

    logic clk;
    logic rst_n = 1'b0;

    logic             in_valid  = 1'b0;
    logic [PIX_W-1:0] in_pixel  = '0;
    logic             in_filler = 1'b0;
    logic             out_ready = 1'b0;

    logic                 cfg_we_r    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index_r = '0;
    logic [CFG_W-1:0]     cfg_wdata_r = '0;

    cwm_pix_in_if  pix_in_ch ();
    cwm_pix_out_if pix_out_ch ();

    assign pix_in_ch.valid     = in_valid;
    assign pix_in_ch.pixel_in  = in_pixel;
    assign pix_in_ch.is_filler = in_filler;
    assign pix_out_ch.ready    = out_ready;

    cross_window_morphology #(
        .MAX_WIDTH (MAX_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch),
        .cfg_we    (cfg_we_r),
        .cfg_index (cfg_index_r),
        .cfg_wdata (cfg_wdata_r)
    );

    // predictor state
    logic [FW_W-1:0]  cfg_width  = WIDTH_RST;
    logic [FH_W-1:0]  cfg_height = HEIGHT_RST;
    logic [PIX_W-1:0] cfg_target = '0;
    logic             cfg_dilate = 1'b0;
    logic [PIX_W-1:0] upper_store [MAX_W];
    logic [PIX_W-1:0] middle_store [MAX_W];
    logic [PIX_W-1:0] win [6];
    raster_pos_t      in_pos   = '0;
    raster_pos_t      plan_pos = '0;

    pix_beat_t     pending_q [$];
    filtered_pix_t filtered_q [$];

    bit          in_fire       = 1'b0;
    int          errors        = 0;
    int unsigned items_queued  = 0;
    int unsigned items_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_seen   = 0;
    longint      cycle_count   = 0;

    // sender burst state and receiver stall state
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned mode_left  = 0;
    int unsigned rx_mode    = 0;
    int unsigned stall_left = 0;
    int unsigned rx_phase   = 0;
    logic        rdy_next;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function int unsigned eff_height();
        return (cfg_height < MIN_SIZE) ? MIN_SIZE : cfg_height;
    endfunction

    function logic [PIX_W-1:0] cross_target();
        return cfg_dilate ? PIX_MAX - cfg_target : cfg_target;
    endfunction

    function automatic raster_pos_t step_raster(input raster_pos_t p, input int unsigned w,
                                               input int unsigned h);
        raster_pos_t n;
        int unsigned c;
        c = (p.col >= w) ? w - 1 : p.col;
        n = p;
        n.at_col = c;
        n.at_row = p.row;
        n.emit = (p.row >= 2) || (p.row == 1 && c >= 1);
        n.done = 1'b0;
        if (c + 1 >= w)
        begin
            n.col = 0;
            n.row = p.row + 1;
        end
        else
        begin
            n.col = c + 1;
        end
        if (n.emit)
        begin
            if (p.cnt >= w * h - 1)
            begin
                n.done = 1'b1;
                n.col = 0;
                n.row = 0;
                n.cnt = 0;
            end
            else
            begin
                n.cnt = p.cnt + 1;
            end
        end
        return n;
    endfunction

    task predict_cross_filter(input logic [PIX_W-1:0] pix_v, input logic filler);
        int unsigned w, h, c, r;
        logic [PIX_W-1:0] p, top, mid, tv, res;
        logic hit;
        w = eff_width();
        h = eff_height();
        in_pos = step_raster(in_pos, w, h);
        c = in_pos.at_col;
        r = in_pos.at_row;
        p = (filler || r >= h) ? '0 : pix_v;
        tv = cross_target();
        top = upper_store[c];
        mid = middle_store[c];
        upper_store[c] = mid;
        middle_store[c] = p;
        res = win[3];
        hit = (win[3] == tv) || (win[1] == tv) || (win[5] == tv) || (win[2] == tv)
              || (mid == tv);
        // center sits one row up and one column left of the incoming beat
        if (in_pos.emit && r >= 2 && r <= h - 1 && c >= 2 && hit)
            res = tv;
        win[0] = win[1];
        win[1] = top;
        win[2] = win[3];
        win[3] = mid;
        win[4] = win[5];
        win[5] = p;
        if (in_pos.emit)
            filtered_q.push_back({res, in_pos.done});
    endtask

    task report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
            $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(input logic [PIX_W-1:0] got_pix, input logic got_last);
        filtered_pix_t exp_beat;
        if (filtered_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat pixel=%0d frame_end=%0b",
                                      got_pix, got_last));
        end
        else
        begin
            exp_beat = filtered_q.pop_front();
            if (got_pix !== exp_beat.pix)
                report_mismatch($sformatf("result %0d pixel_out=%0d, want %0d",
                                          results_seen, got_pix, exp_beat.pix));
            if (got_last !== exp_beat.last)
                report_mismatch($sformatf("result %0d frame_end=%0b, want %0b",
                                          results_seen, got_last, exp_beat.last));
            if (exp_beat.last)
                frames_seen++;
        end
        results_seen++;
    endtask

    // predict on accepted input, then check the output beat of the same edge
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && pix_in_ch.ready;
        if (in_fire)
        begin
            items_taken++;
            predict_cross_filter(in_pixel, in_filler);
        end
        if (rst_n && pix_out_ch.valid && out_ready)
            check_result(pix_out_ch.pixel_out, pix_out_ch.frame_end);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     filtered_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sender: bursts of random length, random gaps, occasional long unbroken runs
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0 || pending_q.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                {in_pixel, in_filler} <= pending_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: switch between always ready, random, periodic and bursty stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            else
            begin
                mode_left--;
            end
            rx_phase++;
            case (rx_mode)
                0: rdy_next = 1'b1;
                1: rdy_next = ($urandom_range(0, 9) < 7);
                2: rdy_next = (rx_phase % 3 != 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rdy_next = 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(1, 10);
                        rdy_next = 1'b0;
                    end
                    else
                    begin
                        rdy_next = 1'b1;
                    end
                end
            endcase
            out_ready <= rdy_next;
        end
    end

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we_r <= 1'b1;
        cfg_index_r <= idx;
        cfg_wdata_r <= value;
        @(negedge clk);
        cfg_we_r <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = value[FW_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = value[FH_W-1:0];
            REG_TARGET_VALUE: cfg_target = value[PIX_W-1:0];
            REG_MORPH_MODE:   cfg_dilate = value[0];
            default: ;
        endcase
    endtask

    // hold until every beat is accepted and every result is back, then let the pipe settle
    task wait_idle();
        while (items_taken != items_queued || filtered_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task push_planned(input logic [PIX_W-1:0] v, input logic f, output bit ended);
        plan_pos = step_raster(plan_pos, eff_width(), eff_height());
        pending_q.push_back({v, f});
        items_queued++;
        ended = plan_pos.done;
    endtask

    function logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = cross_target();
            3:       v = '0;
            4:       v = PIX_MAX;
            default: v = $urandom_range(0, 255);
        endcase
        return v;
    endfunction

    // queue beats of the current frame until it ends or the limit is reached
    task queue_frame(input int unsigned limit, output bit ended);
        int unsigned n;
        raster_pos_t nxt;
        logic [PIX_W-1:0] v;
        logic f;
        ended = 1'b0;
        n = 0;
        while (!ended && n < limit)
        begin
            nxt = step_raster(plan_pos, eff_width(), eff_height());
            if (nxt.at_row < eff_height())
            begin
                f = ($urandom_range(0, 31) == 0);
                v = pick_pixel();
            end
            else
            begin
                // drain slots: real pixels here must be ignored
                f = $urandom_range(0, 1);
                v = $urandom_range(0, 255);
            end
            push_planned(v, f, ended);
            n++;
        end
    endtask

    task run_random_frame();
        bit ended;
        int unsigned v;
        ended = 1'b0;
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 9))
                0:       v = $urandom_range(0, 2);
                1:       v = $urandom_range(13, 48);
                default: v = $urandom_range(3, 12);
            endcase
            write_reg(REG_FRAME_WIDTH, v);
        end
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 9))
                0:       v = $urandom_range(0, 2);
                1:       v = $urandom_range(9, 16);
                default: v = $urandom_range(3, 8);
            endcase
            write_reg(REG_FRAME_HEIGHT, v);
        end
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 255;
                default: v = $urandom_range(0, 255);
            endcase
            write_reg(REG_TARGET_VALUE, v);
        end
        if ($urandom_range(0, 1) != 0)
            write_reg(REG_MORPH_MODE, $urandom_range(0, 1));

        // some frames get new target, mode or height partway through
        if ($urandom_range(0, 5) == 0)
        begin
            queue_frame($urandom_range(1, eff_width() * eff_height()), ended);
            if (!ended)
            begin
                wait_idle();
                write_reg(REG_TARGET_VALUE, $urandom_range(0, 255));
                write_reg(REG_MORPH_MODE, $urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0)
                    write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 10));
            end
        end
        if (!ended)
            queue_frame(NO_LIMIT, ended);
        wait_idle();
    endtask

    initial
    begin
        bit ended;
        int unsigned random_start;
        for (int i = 0; i < MAX_W; i++)
        begin
            upper_store[i] = '0;
            middle_store[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x3 erosion on target 0 with saturated sizes, a filler as center and
        // real pixels in the drain slots
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 2);
        push_planned(8'd255, 1'b0, ended);
        push_planned(8'd128, 1'b0, ended);
        push_planned(8'd255, 1'b0, ended);
        push_planned(8'd255, 1'b0, ended);
        push_planned(8'd99, 1'b1, ended);
        push_planned(8'd255, 1'b0, ended);
        push_planned(8'd1, 1'b0, ended);
        push_planned(8'd255, 1'b0, ended);
        push_planned(8'd127, 1'b0, ended);
        push_planned(8'd0, 1'b1, ended);
        push_planned(8'hAA, 1'b0, ended);
        push_planned(8'h55, 1'b0, ended);
        push_planned(8'd0, 1'b1, ended);
        wait_idle();

        // 4x3 dilation: one center passes, one is hit from below
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_MORPH_MODE, 1);
        push_planned(8'd0, 1'b0, ended);
        push_planned(8'd200, 1'b0, ended);
        push_planned(8'd0, 1'b0, ended);
        push_planned(8'd0, 1'b0, ended);
        push_planned(8'd17, 1'b0, ended);
        push_planned(8'd40, 1'b0, ended);
        push_planned(8'd60, 1'b0, ended);
        push_planned(8'd9, 1'b0, ended);
        push_planned(8'd0, 1'b0, ended);
        push_planned(8'd34, 1'b0, ended);
        push_planned(8'd255, 1'b0, ended);
        push_planned(8'd0, 1'b0, ended);
        while (!ended)
            push_planned(8'd0, 1'b1, ended);
        wait_idle();

        random_start = items_queued;
        while (items_queued - random_start < RANDOM_ITEMS)
            run_random_frame();

        $display("%0d beats sent, %0d results checked over %0d frames", items_queued,
                 results_seen, frames_seen);
        $display("frames from 3x3 up to 48 wide and 16 high, both modes, saturated sizes,");
        $display("fillers, junk in drain slots and mid-frame target, mode and height changes");
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
